### rtl/core/kts_pkg.sv
package kts_pkg;

  // array bounds
  localparam int MAX_GROUPS = 64;
  localparam int MAX_ITEMS  = 16;
  localparam int MAX_DIMS   = 8;
  localparam int TABU_DEPTH = 128;

  // field widths
  localparam int GRP_W  = 6;
  localparam int ITEM_W = 4;
  localparam int DIM_W  = 3;
  localparam int RING_W = 7;
  localparam int AMT_W  = 24;
  localparam int VAL_W  = 30;

  localparam int CONS_AW = GRP_W + ITEM_W + DIM_W;
  localparam int PROF_AW = GRP_W + ITEM_W;

  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  // configuration register indexes
  localparam logic [7:0] REG_GROUP_COUNT = 8'd0;
  localparam logic [7:0] REG_ITEM_COUNT  = 8'd1;
  localparam logic [7:0] REG_DIM_COUNT   = 8'd2;
  localparam logic [7:0] REG_TABU_LENGTH = 8'd3;

  typedef enum logic [2:0] {
    ACT_LOAD_CAP    = 3'd0,
    ACT_LOAD_CONS   = 3'd1,
    ACT_LOAD_PROFIT = 3'd2,
    ACT_CLEAR       = 3'd3,
    ACT_ASSIGN      = 3'd4,
    ACT_SWAP        = 3'd5,
    ACT_IMPROVE     = 3'd6,
    ACT_RECORD      = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_NONE  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_DEC, SQ_CUR, SQ_BSTR, SQ_BSTW, SQ_CANR, SQ_CANW, SQ_FR,
    SQ_FW, SQ_RGR, SQ_RGW, SQ_NXT, SQ_APR, SQ_APW, SQ_FIN, SQ_DONE
  } seq_state_t;

  typedef struct packed {
    logic [6:0] group_count;
    logic [4:0] item_count;
    logic [3:0] dim_count;
    logic [7:0] tabu_length;
  } cfg_t;

  typedef struct packed {
    status_t           status;
    logic [ITEM_W-1:0] chosen_item;
    logic [VAL_W-1:0]  total_value;
    logic [3:0]        violations;
    logic              was_tabu_hit;
  } res_t;

endpackage

### rtl/core/kts_if.sv
interface kts_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [5:0]  group;
  logic [3:0]  item;
  logic [2:0]  dim;
  logic [23:0] amount;
  logic [23:0] profit;

  modport source (output valid, action, group, item, dim, amount, profit, input ready);
  modport sink (input valid, action, group, item, dim, amount, profit, output ready);
endinterface

interface kts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  chosen_item;
  logic [29:0] total_value;
  logic [3:0]  violations;
  logic        was_tabu_hit;

  modport source (output valid, status, chosen_item, total_value, violations, was_tabu_hit,
                  input ready);
  modport sink (input valid, status, chosen_item, total_value, violations, was_tabu_hit,
                output ready);
endinterface

interface kts_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/kts_engine.sv
module kts_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  kts_pkg::cfg_t       cfg,
  input  logic                ring_flush,
  kts_in_if.sink              in_chan,
  output logic                res_valid,
  input  logic                res_ready,
  output kts_pkg::res_t       res
);

  // saturating base - sub + add into the value range
  function automatic logic [kts_pkg::VAL_W-1:0] sat_adj(
    input logic [kts_pkg::VAL_W-1:0] base,
    input logic [kts_pkg::AMT_W-1:0] sub,
    input logic [kts_pkg::AMT_W-1:0] add
  );
    logic signed [kts_pkg::VAL_W+1:0] s;
    s = $signed({2'b00, base}) - $signed({8'd0, sub}) + $signed({8'd0, add});
    if (s < 0) begin
      return '0;
    end else if (s > $signed({2'b00, kts_pkg::VAL_MAX})) begin
      return kts_pkg::VAL_MAX;
    end
    return s[kts_pkg::VAL_W-1:0];
  endfunction

  kts_pkg::seq_state_t state_r, state_nxt;

  // latched transfer
  kts_pkg::action_t          act_r;
  logic [5:0]                g_r;
  logic [3:0]                it_r;
  logic [2:0]                d_r;
  logic [23:0]               amt_r;
  logic [23:0]               pr_r;
  logic                      gok_r;
  logic                      err_r;

  // search registers
  logic [3:0]                cur_r;
  logic [3:0]                ad_r;
  logic                      rm_en_r;
  logic [4:0]                j_r;
  logic [3:0]                k_r;
  logic [23:0]               best_r;
  logic [23:0]               pj_r;
  logic [3:0]                pos_r;
  logic                      found_r;
  logic                      feas_r;
  logic [29:0]               cval_r;
  logic [7:0]                rk_r;
  logic                      hit_r;
  kts_pkg::status_t          status_r;

  // solution state
  logic [29:0]               totals_r [kts_pkg::MAX_DIMS];
  logic [23:0]               cap_r [kts_pkg::MAX_DIMS];
  logic [29:0]               value_r;
  logic [6:0]                head_r;
  logic [6:0]                tail_r;
  logic [7:0]                fill_r;
  logic [kts_pkg::MAX_GROUPS-1:0] choice_vld_r;

  // memories
  logic [23:0] cons_mem [2**kts_pkg::CONS_AW];
  logic [23:0] prof_mem [2**kts_pkg::PROF_AW];
  logic [29:0] tabu_mem [kts_pkg::TABU_DEPTH];
  logic [3:0]  choice_mem [kts_pkg::MAX_GROUPS];
  logic [23:0] cq_a, cq_b, pq_a, pq_b;
  logic [29:0] tq;
  logic [3:0]  chq;

  // effective counts
  logic [6:0] ng;
  logic [4:0] ni;
  logic [3:0] nd;
  logic [7:0] nt;

  assign ng = (cfg.group_count > 7'(kts_pkg::MAX_GROUPS)) ? 7'(kts_pkg::MAX_GROUPS)
                                                          : cfg.group_count;
  assign ni = (cfg.item_count > 5'(kts_pkg::MAX_ITEMS)) ? 5'(kts_pkg::MAX_ITEMS)
                                                        : cfg.item_count;
  assign nd = (cfg.dim_count > 4'(kts_pkg::MAX_DIMS)) ? 4'(kts_pkg::MAX_DIMS)
                                                      : cfg.dim_count;
  assign nt = (cfg.tabu_length == 8'd0) ? 8'd1 :
              (cfg.tabu_length > 8'(kts_pkg::TABU_DEPTH)) ? 8'(kts_pkg::TABU_DEPTH)
                                                          : cfg.tabu_length;

  // range check of the incoming transfer
  kts_pkg::action_t in_act;
  logic in_gok, in_iok, in_dok, in_err;

  assign in_act = kts_pkg::action_t'(in_chan.action);
  assign in_gok = {1'b0, in_chan.group} < ng;
  assign in_iok = {1'b0, in_chan.item} < ni;
  assign in_dok = {1'b0, in_chan.dim} < nd;

  always_comb begin
    case (in_act)
      kts_pkg::ACT_LOAD_CAP:    in_err = !in_dok;
      kts_pkg::ACT_LOAD_CONS:   in_err = !(in_gok && in_iok && in_dok);
      kts_pkg::ACT_LOAD_PROFIT: in_err = !(in_gok && in_iok);
      kts_pkg::ACT_ASSIGN:      in_err = !(in_gok && in_iok);
      kts_pkg::ACT_SWAP:        in_err = !(in_gok && in_iok);
      kts_pkg::ACT_IMPROVE:     in_err = !in_gok;
      default:                  in_err = 1'b0;
    endcase
  end

  // datapath terms
  logic        applying;
  logic [3:0]  b_item;
  logic [29:0] tot_k;
  logic [23:0] cap_k;
  logic [29:0] ap_tot, ap_val, fr_tot, can_val;
  logic        fr_bad, k_in, k_more, j_more, rk_in, rmatch;
  logic [8:0]  rsum;
  logic [6:0]  raddr;
  logic [6:0]  tail_inc, head_inc;

  assign applying = (state_r == kts_pkg::SQ_APR) || (state_r == kts_pkg::SQ_APW);
  assign b_item   = applying ? ad_r : j_r[3:0];
  assign tot_k    = totals_r[k_r[2:0]];
  assign cap_k    = cap_r[k_r[2:0]];
  assign ap_tot   = sat_adj(tot_k, rm_en_r ? cq_a : 24'd0, cq_b);
  assign ap_val   = sat_adj(value_r, rm_en_r ? pq_a : 24'd0, pq_b);
  assign fr_tot   = sat_adj(tot_k, cq_a, cq_b);
  assign can_val  = sat_adj(value_r, pq_a, pq_b);
  assign k_in     = k_r < nd;
  assign fr_bad   = k_in && (fr_tot > {6'd0, cap_k});
  assign k_more   = (k_r + 4'd1) < nd;
  assign j_more   = (j_r + 5'd1) < ni;
  assign rk_in    = rk_r < fill_r;
  assign rmatch   = (tq == cval_r);

  // ring slot of the scan position, wrapped at the ring length
  assign rsum  = {2'b00, head_r} + {1'b0, rk_r};
  assign raddr = (rsum >= {1'b0, nt}) ? 7'(rsum - {1'b0, nt}) : rsum[6:0];
  assign tail_inc = ({1'b0, tail_r} + 8'd1 == nt) ? 7'd0 : 7'(tail_r + 7'd1);
  assign head_inc = ({1'b0, head_r} + 8'd1 == nt) ? 7'd0 : 7'(head_r + 7'd1);

  // memory ports
  always_ff @(posedge clk) begin
    cq_a <= cons_mem[{g_r, cur_r, k_r[2:0]}];
    cq_b <= cons_mem[{g_r, b_item, k_r[2:0]}];
    pq_a <= prof_mem[{g_r, cur_r}];
    pq_b <= prof_mem[{g_r, b_item}];
    tq   <= tabu_mem[raddr];
    chq  <= choice_vld_r[g_r] ? choice_mem[g_r] : 4'd0;
    if (state_r == kts_pkg::SQ_DEC && !err_r && act_r == kts_pkg::ACT_LOAD_CONS) begin
      cons_mem[{g_r, it_r, d_r}] <= amt_r;
    end
    if (state_r == kts_pkg::SQ_DEC && !err_r && act_r == kts_pkg::ACT_LOAD_PROFIT) begin
      prof_mem[{g_r, it_r}] <= pr_r;
    end
    if (state_r == kts_pkg::SQ_RGR && !rk_in && act_r == kts_pkg::ACT_RECORD) begin
      tabu_mem[tail_r] <= cval_r;
    end
    if (state_r == kts_pkg::SQ_APW && !k_more) begin
      choice_mem[g_r] <= ad_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kts_pkg::SQ_IDLE: if (in_chan.valid) state_nxt = kts_pkg::SQ_DEC;
      kts_pkg::SQ_DEC: begin
        if (err_r) begin
          state_nxt = kts_pkg::SQ_FIN;
        end else begin
          case (act_r)
            kts_pkg::ACT_ASSIGN, kts_pkg::ACT_SWAP,
            kts_pkg::ACT_IMPROVE, kts_pkg::ACT_RECORD: state_nxt = kts_pkg::SQ_CUR;
            default:                                  state_nxt = kts_pkg::SQ_FIN;
          endcase
        end
      end
      kts_pkg::SQ_CUR: begin
        case (act_r)
          kts_pkg::ACT_IMPROVE: state_nxt = kts_pkg::SQ_BSTR;
          kts_pkg::ACT_RECORD:  state_nxt = kts_pkg::SQ_RGR;
          default:              state_nxt = kts_pkg::SQ_APR;
        endcase
      end
      kts_pkg::SQ_BSTR: state_nxt = kts_pkg::SQ_BSTW;
      kts_pkg::SQ_BSTW: state_nxt = kts_pkg::SQ_CANR;
      kts_pkg::SQ_CANR: state_nxt = kts_pkg::SQ_CANW;
      kts_pkg::SQ_CANW: begin
        // an item beyond the count in use, the current item, or no profit gain: skip the candidate
        if (j_r >= ni || j_r[3:0] == cur_r || !(best_r < pq_b)) state_nxt = kts_pkg::SQ_NXT;
        else state_nxt = kts_pkg::SQ_FR;
      end
      kts_pkg::SQ_FR: state_nxt = kts_pkg::SQ_FW;
      kts_pkg::SQ_FW: begin
        if (k_more) state_nxt = kts_pkg::SQ_FR;
        else if (feas_r && !fr_bad) state_nxt = kts_pkg::SQ_RGR;
        else state_nxt = kts_pkg::SQ_NXT;
      end
      kts_pkg::SQ_RGR: begin
        if (rk_in) state_nxt = kts_pkg::SQ_RGW;
        else if (act_r == kts_pkg::ACT_IMPROVE) state_nxt = kts_pkg::SQ_NXT;
        else state_nxt = kts_pkg::SQ_FIN;
      end
      kts_pkg::SQ_RGW: begin
        if (!rmatch) state_nxt = kts_pkg::SQ_RGR;
        else if (act_r == kts_pkg::ACT_IMPROVE) state_nxt = kts_pkg::SQ_NXT;
        else state_nxt = kts_pkg::SQ_FIN;
      end
      kts_pkg::SQ_NXT: begin
        if (j_more) state_nxt = kts_pkg::SQ_CANR;
        else if (found_r) state_nxt = kts_pkg::SQ_APR;
        else state_nxt = kts_pkg::SQ_FIN;
      end
      kts_pkg::SQ_APR: state_nxt = kts_pkg::SQ_APW;
      kts_pkg::SQ_APW: state_nxt = k_more ? kts_pkg::SQ_APR : kts_pkg::SQ_FIN;
      kts_pkg::SQ_FIN: state_nxt = kts_pkg::SQ_DONE;
      kts_pkg::SQ_DONE: if (res_ready) state_nxt = kts_pkg::SQ_IDLE;
      default: state_nxt = kts_pkg::SQ_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_chan.ready = (state_r == kts_pkg::SQ_IDLE);
    res_valid     = (state_r == kts_pkg::SQ_DONE);
  end

  // violation recount against the current capacities
  logic [3:0] viol;
  always_comb begin
    viol = 4'd0;
    for (int d = 0; d < kts_pkg::MAX_DIMS; d++) begin
      if (4'(d) < nd && totals_r[d] > {6'd0, cap_r[d]}) viol = viol + 4'd1;
    end
  end

  assign res.status       = status_r;
  assign res.chosen_item  = gok_r ? chq : 4'd0;
  assign res.total_value  = value_r;
  assign res.violations   = viol;
  assign res.was_tabu_hit = hit_r;

  // control and solution state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= kts_pkg::SQ_IDLE;
      value_r      <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      fill_r       <= '0;
      choice_vld_r <= '0;
      for (int d = 0; d < kts_pkg::MAX_DIMS; d++) totals_r[d] <= '0;
    end else begin
      state_r <= state_nxt;
      if (ring_flush) begin
        head_r <= '0;
        tail_r <= '0;
        fill_r <= '0;
      end
      case (state_r)
        kts_pkg::SQ_DEC: begin
          if (!err_r && act_r == kts_pkg::ACT_CLEAR) begin
            value_r      <= '0;
            head_r       <= '0;
            tail_r       <= '0;
            fill_r       <= '0;
            choice_vld_r <= '0;
            for (int d = 0; d < kts_pkg::MAX_DIMS; d++) totals_r[d] <= '0;
          end
        end
        kts_pkg::SQ_RGR: begin
          // insert at the tail, dropping the oldest slot when full
          if (!rk_in && act_r == kts_pkg::ACT_RECORD) begin
            tail_r <= tail_inc;
            if (tail_inc == head_r) head_r <= head_inc;
            else fill_r <= fill_r + 8'd1;
          end
        end
        kts_pkg::SQ_APW: begin
          if (k_in) totals_r[k_r[2:0]] <= ap_tot;
          if (k_r == 4'd0) value_r <= ap_val;
          if (!k_more) choice_vld_r[g_r] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state_r)
      kts_pkg::SQ_IDLE: begin
        act_r    <= in_act;
        g_r      <= in_chan.group;
        it_r     <= in_chan.item;
        d_r      <= in_chan.dim;
        amt_r    <= in_chan.amount;
        pr_r     <= in_chan.profit;
        gok_r    <= in_gok;
        err_r    <= in_err;
        status_r <= in_err ? kts_pkg::ST_RANGE : kts_pkg::ST_DONE;
        hit_r    <= 1'b0;
        k_r      <= '0;
      end
      kts_pkg::SQ_DEC: begin
        if (!err_r && act_r == kts_pkg::ACT_LOAD_CAP) cap_r[d_r] <= amt_r;
      end
      kts_pkg::SQ_CUR: begin
        cur_r   <= chq;
        ad_r    <= it_r;
        rm_en_r <= (act_r != kts_pkg::ACT_ASSIGN);
        cval_r  <= value_r;
        rk_r    <= '0;
        k_r     <= '0;
      end
      kts_pkg::SQ_BSTW: begin
        best_r  <= pq_a;
        j_r     <= '0;
        found_r <= 1'b0;
      end
      kts_pkg::SQ_CANW: begin
        pj_r   <= pq_b;
        cval_r <= can_val;
        k_r    <= '0;
        feas_r <= 1'b1;
        rk_r   <= '0;
      end
      kts_pkg::SQ_FW: begin
        if (fr_bad) feas_r <= 1'b0;
        if (k_more) k_r <= k_r + 4'd1;
      end
      kts_pkg::SQ_RGR: begin
        // scan ran out without a match: candidate survives
        if (!rk_in && act_r == kts_pkg::ACT_IMPROVE) begin
          best_r  <= pj_r;
          pos_r   <= j_r[3:0];
          found_r <= 1'b1;
        end
      end
      kts_pkg::SQ_RGW: begin
        if (rmatch) begin
          if (act_r == kts_pkg::ACT_RECORD) hit_r <= 1'b1;
        end else begin
          rk_r <= rk_r + 8'd1;
        end
      end
      kts_pkg::SQ_NXT: begin
        if (j_more) begin
          j_r <= j_r + 5'd1;
        end else if (found_r) begin
          ad_r    <= pos_r;
          rm_en_r <= 1'b1;
          k_r     <= '0;
        end else begin
          status_r <= kts_pkg::ST_NONE;
        end
      end
      kts_pkg::SQ_APW: begin
        if (k_more) k_r <= k_r + 4'd1;
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/knapsack_tabu_swap_search_core.sv
// Tabu-guarded swap search over a multiple-choice multidimensional knapsack. One result
// per transfer. Consumption (8192 x 24), profit (1024 x 24) and tabu values (128 x 30)
// sit in synchronous memories read once per cycle, so work is set by those reads: loads,
// clear and rejected indexes do no search; assign and swap step over the D dimensions
// in use; record scans up to F filled ring slots; improve checks each of the I items
// in use against the dimensions and the ring. A new transfer is taken once the previous
// result is handed to the output register, which may still be waiting on the consumer.
module knapsack_tabu_swap_search_core (
  input  logic       clk,
  input  logic       rst_n,
  kts_in_if.sink     in_chan,
  kts_out_if.source  out_chan,
  kts_cfg_if.sink    cfg_chan
);

  kts_pkg::cfg_t cfg_r;
  logic          ring_flush;
  logic          cfg_xfer;

  // configuration writes
  assign cfg_chan.ready = 1'b1;
  assign cfg_xfer       = cfg_chan.valid && cfg_chan.ready;
  assign ring_flush     = cfg_xfer && (cfg_chan.index == kts_pkg::REG_TABU_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.group_count <= 7'(kts_pkg::MAX_GROUPS);
      cfg_r.item_count  <= 5'(kts_pkg::MAX_ITEMS);
      cfg_r.dim_count   <= 4'(kts_pkg::MAX_DIMS);
      cfg_r.tabu_length <= 8'(kts_pkg::TABU_DEPTH);
    end else if (cfg_xfer) begin
      case (cfg_chan.index)
        kts_pkg::REG_GROUP_COUNT: cfg_r.group_count <= cfg_chan.data[6:0];
        kts_pkg::REG_ITEM_COUNT:  cfg_r.item_count  <= cfg_chan.data[4:0];
        kts_pkg::REG_DIM_COUNT:   cfg_r.dim_count   <= cfg_chan.data[3:0];
        kts_pkg::REG_TABU_LENGTH: cfg_r.tabu_length <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // search engine
  logic          res_valid;
  logic          res_ready;
  kts_pkg::res_t res;

  kts_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .ring_flush (ring_flush),
    .in_chan    (in_chan),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output register
  logic          out_valid_r;
  kts_pkg::res_t out_r;

  assign res_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_r <= res;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_r.status;
  assign out_chan.chosen_item  = out_r.chosen_item;
  assign out_chan.total_value  = out_r.total_value;
  assign out_chan.violations   = out_r.violations;
  assign out_chan.was_tabu_hit = out_r.was_tabu_hit;

  // one transfer at a time in the engine
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("engine took a transfer while busy");

  // a result never overwrites a pending one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && out_valid_r && !out_chan.ready |=> res_valid)
    else $error("result dropped while output register full");

  // recount never exceeds the dimension bound
  a_viol_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.violations <= 4'(kts_pkg::MAX_DIMS))
    else $error("violation count out of range");

  // a tabu hit only comes from a successful record
  a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.was_tabu_hit |-> out_chan.status == kts_pkg::ST_DONE)
    else $error("tabu hit with failing status");

endmodule

### dv/knapsack_tabu_swap_search_core_tb.sv
module knapsack_tabu_swap_search_core_tb;
  import kts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 30_000_000;
  localparam int     HOLD_CYCLES = 400;
  localparam int     SETTLE      = 50;

  logic clk;
  logic rst_n;

  kts_in_if  in_if();
  kts_out_if out_if();
  kts_cfg_if cfg_if();

  knapsack_tabu_swap_search_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // knapsack shadow state
  logic [AMT_W-1:0] cons_mem [MAX_GROUPS*MAX_ITEMS*MAX_DIMS];
  logic [AMT_W-1:0] prof_mem [MAX_GROUPS*MAX_ITEMS];
  logic [AMT_W-1:0] cap_mem  [MAX_DIMS];
  bit               cons_ok  [MAX_GROUPS*MAX_ITEMS*MAX_DIMS];
  bit               prof_ok  [MAX_GROUPS*MAX_ITEMS];
  logic [VAL_W-1:0] tot_mem  [MAX_DIMS];
  logic [3:0]       pick_mem [MAX_GROUPS];
  logic [VAL_W-1:0] tabu_mem [TABU_DEPTH];
  logic [VAL_W-1:0] sol_val;
  logic [3:0]       viol_cnt;
  int unsigned      ring_hd, ring_tl, ring_cnt;
  cfg_t             cfg_sh;

  res_t    expected_q [$];
  int      fail_cnt;
  longint  cyc_cnt;
  bit      calm;
  bit      hold_req;
  int      hold_left;

  function automatic int unsigned eff_groups();
    return (cfg_sh.group_count > MAX_GROUPS) ? MAX_GROUPS : cfg_sh.group_count;
  endfunction

  function automatic int unsigned eff_items();
    return (cfg_sh.item_count > MAX_ITEMS) ? MAX_ITEMS : cfg_sh.item_count;
  endfunction

  function automatic int unsigned eff_dims();
    return (cfg_sh.dim_count > MAX_DIMS) ? MAX_DIMS : cfg_sh.dim_count;
  endfunction

  function automatic int unsigned eff_tabu();
    if (cfg_sh.tabu_length == 0) return 1;
    return (cfg_sh.tabu_length > TABU_DEPTH) ? TABU_DEPTH : cfg_sh.tabu_length;
  endfunction

  function automatic logic [VAL_W-1:0] clamp_val(longint v);
    if (v < 0) return '0;
    if (v > longint'(VAL_MAX)) return VAL_MAX;
    return v[VAL_W-1:0];
  endfunction

  function automatic int cons_idx(int g, int i, int d);
    return (g * MAX_ITEMS + i) * MAX_DIMS + d;
  endfunction

  function automatic logic [VAL_W-1:0] total_after(int g, int rm, int ad, int d);
    return clamp_val(longint'(tot_mem[d]) - longint'(cons_mem[cons_idx(g, rm, d)])
                     + longint'(cons_mem[cons_idx(g, ad, d)]));
  endfunction

  function automatic logic [VAL_W-1:0] value_after(int g, int rm, int ad);
    return clamp_val(longint'(sol_val) - longint'(prof_mem[g*MAX_ITEMS+rm])
                     + longint'(prof_mem[g*MAX_ITEMS+ad]));
  endfunction

  function automatic bit fits(int g, int rm, int ad);
    for (int d = 0; d < eff_dims(); d++)
      if (total_after(g, rm, ad, d) > cap_mem[d]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit is_tabu(logic [VAL_W-1:0] v);
    for (int unsigned k = 0; k < ring_cnt; k++)
      if (tabu_mem[(ring_hd + k) % eff_tabu()] == v) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void apply_swap(int g, int ad);
    int rm;
    rm = pick_mem[g];
    for (int d = 0; d < eff_dims(); d++) tot_mem[d] = total_after(g, rm, ad, d);
    sol_val = value_after(g, rm, ad);
    pick_mem[g] = ad[3:0];
  endfunction

  // group whose whole table has been loaded, so any search on it is defined
  function automatic bit group_loaded(int g);
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (!prof_ok[g*MAX_ITEMS+i]) return 1'b0;
      for (int d = 0; d < MAX_DIMS; d++)
        if (!cons_ok[cons_idx(g, i, d)]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // expected result of one accepted transfer, updating the shadow state
  function automatic res_t predict_step(action_t act, int g, int it, int d,
                                        logic [AMT_W-1:0] amt, logic [AMT_W-1:0] pr);
    res_t r;
    bit gok, iok, dok, found;
    int cur, pos;
    logic [AMT_W-1:0] best, pj;
    int unsigned c;
    gok = g < eff_groups();
    iok = it < eff_items();
    dok = d < eff_dims();
    r = '0;
    r.status = ST_DONE;
    case (act)
      ACT_LOAD_CAP: begin
        if (!dok) r.status = ST_RANGE;
        else cap_mem[d] = amt;
      end
      ACT_LOAD_CONS: begin
        if (!gok || !iok || !dok) r.status = ST_RANGE;
        else begin
          cons_mem[cons_idx(g, it, d)] = amt;
          cons_ok[cons_idx(g, it, d)] = 1'b1;
        end
      end
      ACT_LOAD_PROFIT: begin
        if (!gok || !iok) r.status = ST_RANGE;
        else begin
          prof_mem[g*MAX_ITEMS+it] = pr;
          prof_ok[g*MAX_ITEMS+it] = 1'b1;
        end
      end
      ACT_CLEAR: begin
        foreach (tot_mem[k]) tot_mem[k] = '0;
        foreach (pick_mem[k]) pick_mem[k] = '0;
        sol_val = '0;
        ring_hd = 0; ring_tl = 0; ring_cnt = 0;
      end
      ACT_ASSIGN: begin
        if (!gok || !iok) r.status = ST_RANGE;
        else begin
          for (int k = 0; k < eff_dims(); k++)
            tot_mem[k] = clamp_val(longint'(tot_mem[k]) + longint'(cons_mem[cons_idx(g, it, k)]));
          sol_val = clamp_val(longint'(sol_val) + longint'(prof_mem[g*MAX_ITEMS+it]));
          pick_mem[g] = it[3:0];
        end
      end
      ACT_SWAP: begin
        if (!gok || !iok) r.status = ST_RANGE;
        else apply_swap(g, it);
      end
      ACT_IMPROVE: begin
        if (!gok) r.status = ST_RANGE;
        else begin
          cur = pick_mem[g];
          best = prof_mem[g*MAX_ITEMS+cur];
          found = 1'b0;
          pos = 0;
          for (int j = 0; j < eff_items(); j++) begin
            pj = prof_mem[g*MAX_ITEMS+j];
            if (j != cur && best < pj && fits(g, cur, j) && !is_tabu(value_after(g, cur, j))) begin
              best = pj;
              pos = j;
              found = 1'b1;
            end
          end
          if (found) apply_swap(g, pos);
          else r.status = ST_NONE;
        end
      end
      default: begin
        if (is_tabu(sol_val)) r.was_tabu_hit = 1'b1;
        else begin
          tabu_mem[ring_tl % eff_tabu()] = sol_val;
          ring_tl = (ring_tl + 1) % eff_tabu();
          if (ring_tl == ring_hd) ring_hd = (ring_hd + 1) % eff_tabu();
          else ring_cnt++;
        end
      end
    endcase
    c = 0;
    for (int k = 0; k < eff_dims(); k++)
      if (tot_mem[k] > cap_mem[k]) c++;
    viol_cnt = c[3:0];
    r.chosen_item = gok ? pick_mem[g] : '0;
    r.total_value = sol_val;
    r.violations = viol_cnt;
    return r;
  endfunction

  // input transfers feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      expected_q.push_back(predict_step(action_t'(in_if.action), in_if.group, in_if.item,
                                        in_if.dim, in_if.amount, in_if.profit));
  end

  // result transfers are compared with the oldest expectation
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, actual status=%0d item=%0d value=%0h viol=%0d hit=%0d",
                 $time, out_if.status, out_if.chosen_item, out_if.total_value,
                 out_if.violations, out_if.was_tabu_hit);
        fail_cnt++;
      end else begin
        e = expected_q.pop_front();
        if (out_if.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_if.status);
          fail_cnt++;
        end
        if (out_if.chosen_item !== e.chosen_item) begin
          $display("%0t: chosen_item expected %0d actual %0d", $time, e.chosen_item,
                   out_if.chosen_item);
          fail_cnt++;
        end
        if (out_if.total_value !== e.total_value) begin
          $display("%0t: total_value expected %0h actual %0h", $time, e.total_value,
                   out_if.total_value);
          fail_cnt++;
        end
        if (out_if.violations !== e.violations) begin
          $display("%0t: violations expected %0d actual %0d", $time, e.violations,
                   out_if.violations);
          fail_cnt++;
        end
        if (out_if.was_tabu_hit !== e.was_tabu_hit) begin
          $display("%0t: was_tabu_hit expected %0d actual %0d", $time, e.was_tabu_hit,
                   out_if.was_tabu_hit);
          fail_cnt++;
        end
      end
    end
  end

  // result consumer: random stalls, calm stretches and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_if.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_if.ready <= calm || ($urandom_range(0, 99) >= 7);
    end
  end

  // run limit
  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one input transfer; valid stays high into the next item unless the sender idles
  task automatic send_item(action_t act, int g, int it, int d,
                           logic [AMT_W-1:0] amt, logic [AMT_W-1:0] pr);
    bit taken;
    int gap;
    if (!calm && $urandom_range(0, 99) < 7) begin
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.action <= act;
    in_if.group  <= g[5:0];
    in_if.item   <= it[3:0];
    in_if.dim    <= d[2:0];
    in_if.amount <= amt;
    in_if.profit <= pr;
    do begin
      @(negedge clk);
      taken = in_if.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [7:0] data);
    bit taken;
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do begin
      @(negedge clk);
      taken = cfg_if.ready;
      @(posedge clk);
    end while (!taken);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_GROUP_COUNT: cfg_sh.group_count = data[6:0];
      REG_ITEM_COUNT:  cfg_sh.item_count = data[4:0];
      REG_DIM_COUNT:   cfg_sh.dim_count = data[3:0];
      default: begin
        cfg_sh.tabu_length = data;
        ring_hd = 0; ring_tl = 0; ring_cnt = 0;
      end
    endcase
  endtask

  function automatic logic [AMT_W-1:0] rand_amount();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return AMT_W'($urandom());
      2:       return '0;
      default: return AMT_W'($urandom_range(0, 3000));
    endcase
  endfunction

  function automatic logic [AMT_W-1:0] rand_profit();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return AMT_W'($urandom());
      default: return AMT_W'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  // random action; searches only address groups with fully loaded tables
  task automatic send_random();
    int sel, g;
    action_t act;
    sel = $urandom_range(0, 99);
    if (sel < 6)       act = ACT_LOAD_CAP;
    else if (sel < 12) act = ACT_LOAD_CONS;
    else if (sel < 17) act = ACT_LOAD_PROFIT;
    else if (sel < 21) act = ACT_CLEAR;
    else if (sel < 34) act = ACT_ASSIGN;
    else if (sel < 52) act = ACT_SWAP;
    else if (sel < 82) act = ACT_IMPROVE;
    else               act = ACT_RECORD;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 2);
    if ((act == ACT_ASSIGN || act == ACT_SWAP || act == ACT_IMPROVE) &&
        g < eff_groups() && !group_loaded(g))
      g = $urandom_range(0, 2);
    if (act == ACT_LOAD_CAP)
      send_item(act, g, $urandom_range(0, 15), $urandom_range(0, 7),
                AMT_W'($urandom_range(1000, 30000)), rand_profit());
    else
      send_item(act, g, $urandom_range(0, 15), $urandom_range(0, 7), rand_amount(),
                rand_profit());
  endtask

  // capacities first, widening the dimension count one step at a time
  task automatic test_capacity_bring_up();
    for (int d = 0; d < MAX_DIMS; d++) begin
      write_reg(REG_DIM_COUNT, 8'(d + 1));
      send_item(ACT_LOAD_CAP, 0, 0, d, (d == 7) ? 24'hffffff : 24'(20000 + d), 24'd0);
      // first dimension beyond the count is rejected
      if (d + 1 < MAX_DIMS) send_item(ACT_LOAD_CAP, 0, 0, d + 1, 24'd1, 24'd0);
    end
  endtask

  // full tables for the working groups
  task automatic test_load_groups();
    for (int g = 0; g < 3; g++)
      for (int i = 0; i < MAX_ITEMS; i++) begin
        send_item(ACT_LOAD_PROFIT, g, i, 0, 24'd0, rand_profit());
        for (int d = 0; d < MAX_DIMS; d++)
          send_item(ACT_LOAD_CONS, g, i, d, AMT_W'($urandom_range(0, 3000)), 24'd0);
      end
  endtask

  // each operation, tabu hit, range errors and value clamping at zero
  task automatic test_directed();
    send_item(ACT_LOAD_PROFIT, 0, 0, 0, 24'd0, 24'hffffff);
    send_item(ACT_LOAD_PROFIT, 0, 1, 0, 24'd0, 24'd1);
    send_item(ACT_SWAP, 0, 1, 0, 24'd0, 24'd0);
    send_item(ACT_ASSIGN, 1, 3, 0, 24'd0, 24'd0);
    send_item(ACT_ASSIGN, 2, 15, 7, 24'd0, 24'd0);
    send_item(ACT_SWAP, 1, 5, 0, 24'd0, 24'd0);
    send_item(ACT_RECORD, 0, 0, 0, 24'd0, 24'd0);
    send_item(ACT_RECORD, 0, 0, 0, 24'd0, 24'd0);
    send_item(ACT_IMPROVE, 1, 0, 0, 24'd0, 24'd0);
    send_item(ACT_IMPROVE, 0, 0, 0, 24'd0, 24'd0);
    send_item(ACT_RECORD, 0, 0, 0, 24'd0, 24'd0);
    send_item(ACT_IMPROVE, 2, 0, 0, 24'd0, 24'd0);
    send_item(ACT_CLEAR, 63, 15, 7, 24'hffffff, 24'hffffff);
    send_item(ACT_RECORD, 63, 15, 7, 24'hffffff, 24'hffffff);
    write_reg(REG_GROUP_COUNT, 3);
    write_reg(REG_ITEM_COUNT, 15);
    send_item(ACT_ASSIGN, 63, 0, 0, 24'd0, 24'd0);
    send_item(ACT_SWAP, 0, 15, 0, 24'd0, 24'd0);
    send_item(ACT_IMPROVE, 3, 0, 0, 24'd0, 24'd0);
    send_item(ACT_LOAD_PROFIT, 5, 0, 0, 24'd0, 24'd7);
    send_item(ACT_LOAD_CONS, 0, 15, 0, 24'd7, 24'd0);
    write_reg(REG_DIM_COUNT, 7);
    send_item(ACT_LOAD_CAP, 0, 0, 7, 24'd5, 24'd0);
    write_reg(REG_GROUP_COUNT, 64);
    write_reg(REG_ITEM_COUNT, 16);
    write_reg(REG_DIM_COUNT, 8);
  endtask

  // repeated assigns of the largest profit drive value and totals to the ceiling
  task automatic test_saturation();
    send_item(ACT_LOAD_PROFIT, 2, 4, 0, 24'd0, 24'hffffff);
    send_item(ACT_LOAD_CONS, 2, 4, 0, 24'hffffff, 24'd0);
    for (int n = 0; n < 68; n++) send_item(ACT_ASSIGN, 2, 4, 0, 24'd0, 24'd0);
    send_item(ACT_SWAP, 2, 6, 0, 24'd0, 24'd0);
    send_item(ACT_RECORD, 0, 0, 0, 24'd0, 24'd0);
    send_item(ACT_CLEAR, 0, 0, 0, 24'd0, 24'd0);
  endtask

  // register settings including both extremes and out-of-range codes
  task automatic test_config_sweep();
    int gc[6] = '{1, 0, 127, 3, 5, 64};
    int ic[6] = '{1, 0, 31, 2, 16, 16};
    int dc[6] = '{1, 0, 15, 3, 4, 8};
    int tl[6] = '{1, 0, 255, 2, 7, 128};
    for (int s = 0; s < 6; s++) begin
      write_reg(REG_GROUP_COUNT, 8'(gc[s]));
      write_reg(REG_ITEM_COUNT, 8'(ic[s]));
      write_reg(REG_DIM_COUNT, 8'(dc[s]));
      write_reg(REG_TABU_LENGTH, 8'(tl[s]));
      send_item(ACT_CLEAR, 0, 0, 0, 24'd0, 24'd0);
      repeat (45) send_random();
    end
  endtask

  // long consumer hold-off while items keep coming, then a full drain and a calm stretch
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (3) @(posedge clk);
    hold_req = 1'b0;
    repeat (12) send_random();
    wait_drained();
    calm = 1'b1;
    repeat (150) send_random();
    calm = 1'b0;
  endtask

  task automatic test_random_bulk();
    repeat (250) send_random();
    write_reg(REG_TABU_LENGTH, 4);
    repeat (120) send_random();
    write_reg(REG_TABU_LENGTH, 128);
  endtask

  initial begin
    fail_cnt = 0;
    cyc_cnt = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.action = ACT_LOAD_CAP;
    in_if.group = '0;
    in_if.item = '0;
    in_if.dim = '0;
    in_if.amount = '0;
    in_if.profit = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    foreach (cons_ok[k]) cons_ok[k] = 1'b0;
    foreach (prof_ok[k]) prof_ok[k] = 1'b0;
    foreach (tot_mem[k]) tot_mem[k] = '0;
    foreach (pick_mem[k]) pick_mem[k] = '0;
    sol_val = '0;
    viol_cnt = '0;
    ring_hd = 0; ring_tl = 0; ring_cnt = 0;
    cfg_sh.group_count = 7'd64;
    cfg_sh.item_count = 5'd16;
    cfg_sh.dim_count = 4'd8;
    cfg_sh.tabu_length = 8'd128;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_capacity_bring_up();
    test_load_groups();
    test_directed();
    test_saturation();
    test_config_sweep();
    test_backpressure();
    test_random_bulk();

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/kts_pkg.sv
rtl/core/kts_if.sv
rtl/core/kts_engine.sv
rtl/core/knapsack_tabu_swap_search_core.sv
dv/knapsack_tabu_swap_search_core_tb.sv
